// ----- src/rmsm_pkg.sv -----
// Shared types and constants for the RMS current meter.
// Used by every module of the block; depends on nothing.
package rmsm_pkg;

    localparam int SMP_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int WIN_W      = 13;
    localparam int SUM_W      = 48;
    localparam int MA_W       = 20;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int PROD_W     = ROOT_W + GAIN_W;
    localparam int ITER_W     = $clog2(ROOT_W);
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int WIN_MAX    = (1 << WIN_W) - 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [MA_W-1:0]   MA_MAX      = {MA_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 24'd245760;
    localparam logic [WIN_W-1:0]  SPW_RESET   = 13'd430;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPW  = 2'd2;

    // One finished window, as handed from the front end to the back end
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [WIN_W-1:0] valid;
        logic             ok;
    } win_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV_MS,
        B_SQRT,
        B_SCALE,
        B_SAT,
        B_MEAN,
        B_EMIT
    } back_state_t;

endpackage

// ----- src/rmsm_front.sv -----
// Front end: takes sample transactions, accumulates squares and closes windows.
// Depends on rmsm_pkg.
module rmsm_front #(
    parameter int MAX_WINDOW_SLOTS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmsm_pkg::SMP_W-1:0]   sample,
    input  logic                                sample_ok,
    input  logic signed [rmsm_pkg::SMP_W-1:0]   bias,
    input  logic        [rmsm_pkg::WIN_W-1:0]   spw,
    input  logic                                q_full,
    output logic                                win_push,
    output rmsm_pkg::win_t                      win_data
);
    import rmsm_pkg::*;

    localparam int N_CAP = (MAX_WINDOW_SLOTS > WIN_MAX) ? WIN_MAX : MAX_WINDOW_SLOTS;

    logic [SUM_W-1:0]      sum_reg,   sum_next;
    logic [WIN_W-1:0]      valid_reg, valid_next;
    logic [WIN_W-1:0]      slot_reg,  slot_next;

    logic                  accept;
    logic [WIN_W-1:0]      n;
    logic [WIN_W+1:0]      n3;
    logic [WIN_W-1:0]      quorum;
    logic signed [SMP_W:0] diff;
    logic [SMP_W:0]        mag;
    logic [2*SMP_W+1:0]    sq;
    logic [SUM_W-1:0]      sum_upd;
    logic [WIN_W-1:0]      valid_upd;
    logic [WIN_W-1:0]      slot_upd;
    logic                  close;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (spw == '0)
        begin
            n = WIN_W'(1);
        end
        else if (spw > WIN_W'(N_CAP))
        begin
            n = WIN_W'(N_CAP);
        end
        else
        begin
            n = spw;
        end
    end

    assign n3     = {1'b0, n, 1'b0} + {2'b00, n};
    assign quorum = n3[WIN_W+1:2];

    assign diff = {sample[SMP_W-1], sample} - {bias[SMP_W-1], bias};
    assign mag  = diff[SMP_W] ? (SMP_W+1)'(-diff) : (SMP_W+1)'(diff);
    assign sq   = mag * mag;

    assign sum_upd   = sample_ok ? (sum_reg + SUM_W'(sq)) : sum_reg;
    assign valid_upd = valid_reg + WIN_W'(sample_ok);
    assign slot_upd  = slot_reg + WIN_W'(1);
    assign close     = slot_upd >= n;

    always_comb
    begin
        sum_next   = sum_reg;
        valid_next = valid_reg;
        slot_next  = slot_reg;
        win_push   = 1'b0;
        if (accept)
        begin
            if (close)
            begin
                // hand the window over and start the next one empty
                win_push   = 1'b1;
                sum_next   = '0;
                valid_next = '0;
                slot_next  = '0;
            end
            else
            begin
                sum_next   = sum_upd;
                valid_next = valid_upd;
                slot_next  = slot_upd;
            end
        end
    end

    assign win_data.sum   = sum_upd;
    assign win_data.valid = valid_upd;
    assign win_data.ok    = valid_upd >= quorum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// ----- src/rmsm_queue.sv -----
// Short queue of finished windows between front end and back end.
// Depends on rmsm_pkg.
module rmsm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rmsm_pkg::win_t        push_data,
    input  logic                  pop,
    output rmsm_pkg::win_t        head,
    output rmsm_pkg::q_status_t   status
);
    import rmsm_pkg::*;

    win_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg,  count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/rmsm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rmsm_pkg.
module rmsm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rmsm_pkg::SUM_W-1:0]   dividend,
    input  logic [rmsm_pkg::WIN_W-1:0]   divisor,
    output logic                         done,
    output logic [rmsm_pkg::SUM_W-1:0]   quotient
);
    import rmsm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [SUM_W-1:0]     q_reg,    q_next;
    logic [WIN_W-1:0]     rem_reg,  rem_next;
    logic [WIN_W-1:0]     dvs_reg,  dvs_next;
    logic [WIN_W:0]       rem_sh;

    assign rem_sh = {rem_reg, q_reg[SUM_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = WIN_W'(rem_sh - {1'b0, dvs_reg});
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WIN_W-1:0];
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

// ----- src/rmsm_back.sv -----
// Back end: mean square, square root, scaling, history ring and result register.
// Depends on rmsm_pkg and rmsm_div.
module rmsm_back #(
    parameter int HISTORY_DEPTH = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmsm_pkg::win_t                head,
    input  rmsm_pkg::q_status_t           q_status,
    output logic                          pop,
    input  logic [rmsm_pkg::GAIN_W-1:0]   gain,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rmsm_pkg::MA_W-1:0]     smoothed_ma,
    output logic [rmsm_pkg::MA_W-1:0]     window_rms_ma,
    output logic                          window_accepted,
    output logic [rmsm_pkg::WIN_W-1:0]    valid_in_window
);
    import rmsm_pkg::*;

    localparam int POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int TOT_W = MA_W + $clog2(HISTORY_DEPTH + 1);
    // Ring mean by reciprocal multiplication, exact for every total below 2**TOT_W
    localparam int              RCP_SH   = TOT_W + $clog2(HISTORY_DEPTH);
    localparam longint          RCP_FULL = ((longint'(1) << RCP_SH) + longint'(HISTORY_DEPTH)
                                            - longint'(1)) / longint'(HISTORY_DEPTH);
    localparam logic [TOT_W:0]  RCP      = (TOT_W+1)'(RCP_FULL);

    back_state_t        state_reg, state_next;

    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_dividend;
    logic [WIN_W-1:0]   div_divisor;
    logic [SUM_W-1:0]   div_quot;

    logic [WIN_W-1:0]   valid_reg;
    logic               ok_reg;
    logic [SUM_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [MA_W-1:0]    win_ma_reg;
    logic [MA_W-1:0]    mean_reg;

    logic [MA_W-1:0]    hist_reg [HISTORY_DEPTH];
    logic [POS_W-1:0]   pos_reg;
    logic [TOT_W-1:0]   total_reg;

    logic               out_valid_reg;
    logic [MA_W-1:0]    smoothed_reg;
    logic [MA_W-1:0]    rms_reg;
    logic               acc_reg;
    logic [WIN_W-1:0]   vin_reg;

    logic               out_free;
    logic               emit;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               take;
    logic [MA_W-1:0]    sat_ma;
    logic [2*TOT_W:0]   mean_prod;

    rmsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_free     = !out_valid_reg || !out_stall;
    assign div_dividend = head.sum;
    assign div_divisor  = head.valid;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (!head.ok)
                    begin
                        state_next = B_MEAN;
                    end
                    else if (head.valid == '0)
                    begin
                        state_next = B_SCALE;
                    end
                    else
                    begin
                        state_next = B_DIV_MS;
                    end
                end
            end
            B_DIV_MS:
            begin
                if (div_done)
                begin
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    state_next = B_SCALE;
                end
            end
            B_SCALE:   state_next = B_SAT;
            B_SAT:     state_next = B_MEAN;
            B_MEAN:    state_next = B_EMIT;
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:   state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop       = !q_status.empty;
                div_start = !q_status.empty && head.ok && (head.valid != '0);
            end
            B_EMIT:    emit = out_free;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Square root: two radicand bits per step
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign take   = rem_sh >= trial;

    assign sat_ma = (prod_reg[PROD_W-1:MA_W+16] != '0) ? MA_MAX : prod_reg[MA_W+15:16];

    assign mean_prod = total_reg * RCP;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                valid_reg  <= head.valid;
                ok_reg     <= head.ok;
                root_reg   <= '0;
                win_ma_reg <= '0;
            end
            B_DIV_MS:
            begin
                rad_reg  <= div_quot;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            B_SQRT:
            begin
                rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], take};
                iter_reg <= iter_reg + ITER_W'(1);
            end
            B_SCALE:   prod_reg   <= root_reg * gain;
            B_SAT:     win_ma_reg <= sat_ma;
            B_MEAN:    mean_reg   <= mean_prod[RCP_SH +: MA_W];
            default:
            begin
                mean_reg <= mean_reg;
            end
        endcase
        if (emit)
        begin
            smoothed_reg <= mean_reg;
            rms_reg      <= win_ma_reg;
            acc_reg      <= ok_reg;
            vin_reg      <= valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pos_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_SAT)
            begin
                // replace the oldest entry and keep the running total in step
                total_reg         <= total_reg - TOT_W'(hist_reg[pos_reg]) + TOT_W'(sat_ma);
                hist_reg[pos_reg] <= sat_ma;
                pos_reg           <= (pos_reg == POS_W'(HISTORY_DEPTH - 1)) ?
                                     '0 : pos_reg + POS_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign smoothed_ma     = smoothed_reg;
    assign window_rms_ma   = rms_reg;
    assign window_accepted = acc_reg;
    assign valid_in_window = vin_reg;

endmodule

// ----- src/ac_rms_current_meter_with_smoothing.sv -----
// True-RMS current meter: one sample transaction per cycle while the window queue has room.
// An accepted window passes pop, the 48-step mean-square divider, 24 root steps, scaling,
// saturation, averaging and emit. A rejected window goes from pop straight to averaging
// and emit; one with no valid sample skips only the divider and root. The back end works
// one window at a time; two more queue up, then the input stalls until the back end pops one.
// Reset (rst_n, asynchronous, active low) clears accumulators, ring and queue, loads defaults.
module ac_rms_current_meter_with_smoothing #(
    parameter int HISTORY_DEPTH    = 6,
    parameter int MAX_WINDOW_SLOTS = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [rmsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [rmsm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rmsm_pkg::SMP_W-1:0]     sample,
    input  logic                                  sample_ok,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [rmsm_pkg::MA_W-1:0]      smoothed_ma,
    output logic        [rmsm_pkg::MA_W-1:0]      window_rms_ma,
    output logic                                  window_accepted,
    output logic        [rmsm_pkg::WIN_W-1:0]     valid_in_window
);
    import rmsm_pkg::*;

    logic signed [SMP_W-1:0] bias_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [WIN_W-1:0]        spw_reg;

    logic                    win_push;
    win_t                    win_data;
    win_t                    q_head;
    q_status_t               q_status;
    logic                    q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
            gain_reg <= GAIN_RESET;
            spw_reg  <= SPW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIAS: bias_reg <= cfg_data[SMP_W-1:0];
                CFG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_SPW:  spw_reg  <= cfg_data[WIN_W-1:0];
                default:  bias_reg <= bias_reg;
            endcase
        end
    end

    rmsm_front #(
        .MAX_WINDOW_SLOTS (MAX_WINDOW_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .sample_ok (sample_ok),
        .bias      (bias_reg),
        .spw       (spw_reg),
        .q_full    (q_status.full),
        .win_push  (win_push),
        .win_data  (win_data)
    );

    rmsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (win_push),
        .push_data (win_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    rmsm_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .q_status        (q_status),
        .pop             (q_pop),
        .gain            (gain_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .smoothed_ma     (smoothed_ma),
        .window_rms_ma   (window_rms_ma),
        .window_accepted (window_accepted),
        .valid_in_window (valid_in_window)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the RMS current meter: drives sample transactions and register
// writes, predicts each closed window's result and checks every output transaction.
// Depends on rmsm_pkg and ac_rms_current_meter_with_smoothing.
module tb_top;

    import rmsm_pkg::*;

    localparam int HIST_DEPTH    = 6;
    localparam int MAX_SLOTS     = 4096;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 1500;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int RAND_ITEMS    = 560;
    localparam int LONG_WIN      = 300;
    localparam int TAIL_ITEMS    = 60;
    localparam int N_DIR         = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MA_W-1:0]  mean_ma;
        logic [MA_W-1:0]  rms_ma;
        logic             accepted;
        logic [WIN_W-1:0] n_valid;
    } meter_result_t;

    typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;

    typedef struct packed {
        row_kind_e               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [SMP_W-1:0] smp;
        logic                    ok;
        logic                    typed;
        meter_result_t           want;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [SMP_W-1:0] sample = '0;
    logic                    sample_ok = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [MA_W-1:0]         smoothed_ma;
    logic [MA_W-1:0]         window_rms_ma;
    logic                    window_accepted;
    logic [WIN_W-1:0]        valid_in_window;

    // Predictor state
    logic signed [SMP_W-1:0] bias_q = '0;
    logic [GAIN_W-1:0]       gain_q = GAIN_RESET;
    logic [WIN_W-1:0]        spw_q = SPW_RESET;
    logic [SUM_W-1:0]        sum_sq = '0;
    int                      valid_cnt = 0;
    int                      slot_cnt = 0;
    logic [MA_W-1:0]         ring [HIST_DEPTH] = '{default: '0};
    int                      ring_pos = 0;
    logic [22:0]             ring_total = '0;

    meter_result_t           pending_windows [$];
    int                      mismatches = 0;
    int                      cycle_cnt = 0;
    int                      stall_pct = 0;
    logic                    hold_go = 1'b0;
    logic                    hold_done = 1'b0;
    int                      hold_cnt = 0;
    int                      idle_pct = 0;
    bit                      regs_idle = 1'b1;

    stim_row_t dir_rows [N_DIR] = '{
        '{ROW_CFG, CFG_SPW,    24'd1,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd100,   1'b1, 1'b1,
          '{20'd62, 20'd375, 1'b1, 13'd1}},
        // no valid sample, yet a one-slot window is still accepted
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd0,     1'b0, 1'b1,
          '{20'd62, 20'd0, 1'b1, 13'd0}},
        '{ROW_CFG, CFG_BIAS,   24'h008000,  16'sd0,     1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN,   24'hFFFFFF,  16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sh7FFF,  1'b1, 1'b1,
          '{20'd174825, 20'd1048575, 1'b1, 13'd1}},
        '{ROW_CFG, CFG_BIAS,   24'h007FFF,  16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sh8000,  1'b1, 1'b1,
          '{20'd349587, 20'd1048575, 1'b1, 13'd1}},
        '{ROW_CFG, CFG_GAIN,   24'd0,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd12345, 1'b1, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN,   24'h010000,  16'sd0,     1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_BIAS,   24'd0,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_SPW,    24'd4,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       -16'sd3,    1'b1, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd4,     1'b1, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd12,    1'b1, 1'b0, '0},
        // too few valid slots: window rejected
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd5,     1'b1, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd6,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd7,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd8,     1'b1, 1'b0, '0},
        '{ROW_CFG, CFG_SPW,    24'd0,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_UNUSED, 24'hA5A5A5,  16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd1000,  1'b1, 1'b0, '0},
        '{ROW_CFG, CFG_SPW,    24'd10,      16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd11,    1'b1, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       -16'sd22,   1'b1, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd33,    1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       -16'sd44,   1'b1, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd55,    1'b1, 1'b0, '0},
        // window shortened below the slots already taken: closes on the next one
        '{ROW_CFG, CFG_SPW,    24'd3,       16'sd0,     1'b0, 1'b0, '0},
        '{ROW_SMP, CFG_BIAS,   24'd0,       16'sd66,    1'b1, 1'b0, '0}
    };

    ac_rms_current_meter_with_smoothing u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .sample_ok       (sample_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .smoothed_ma     (smoothed_ma),
        .window_rms_ma   (window_rms_ma),
        .window_accepted (window_accepted),
        .valid_in_window (valid_in_window)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once requested
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES)
                hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        meter_result_t got;
        meter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{smoothed_ma, window_rms_ma, window_accepted, valid_in_window};
            if (pending_windows.size() == 0)
            begin
                $display("%0t: unexpected result: mean %0d rms %0d accepted %0b valid %0d",
                         $time, got.mean_ma, got.rms_ma, got.accepted, got.n_valid);
                mismatches++;
            end
            else
            begin
                want = pending_windows.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected mean %0d rms %0d accepted %0b valid %0d",
                             $time, want.mean_ma, want.rms_ma, want.accepted, want.n_valid);
                    $display("%0t: actual   mean %0d rms %0d accepted %0b valid %0d",
                             $time, got.mean_ma, got.rms_ma, got.accepted, got.n_valid);
                    mismatches++;
                end
            end
        end
    end

    // One sample slot through the meter; closed is set when it ends a window
    task automatic rms_window_step(input logic signed [SMP_W-1:0] s, input logic ok,
                                   output bit closed, output meter_result_t res);
        longint          diff;
        int              n;
        int              b;
        longint unsigned mean_sq;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned scaled;
        n = int'(spw_q);
        if (n < 1)
            n = 1;
        if (n > MAX_SLOTS)
            n = MAX_SLOTS;
        if (ok)
        begin
            diff      = longint'(s) - longint'(bias_q);
            sum_sq    = sum_sq + SUM_W'(diff * diff);
            valid_cnt = valid_cnt + 1;
        end
        slot_cnt = slot_cnt + 1;
        closed   = 1'b0;
        res      = '0;
        if (slot_cnt >= n)
        begin
            closed      = 1'b1;
            res.n_valid = WIN_W'(valid_cnt);
            if (valid_cnt >= (n * 3) / 4)
            begin
                mean_sq = (valid_cnt != 0) ? longint'(sum_sq) / valid_cnt : 0;
                root    = 0;
                for (b = ROOT_W - 1; b >= 0; b--)
                begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= mean_sq)
                        root = trial;
                end
                scaled = (root * longint'(gain_q)) >> 16;
                if (scaled > longint'(MA_MAX))
                    scaled = longint'(MA_MAX);
                res.rms_ma     = MA_W'(scaled);
                res.accepted   = 1'b1;
                ring_total     = ring_total - ring[ring_pos] + res.rms_ma;
                ring[ring_pos] = res.rms_ma;
                ring_pos       = (ring_pos + 1) % HIST_DEPTH;
            end
            res.mean_ma = MA_W'(ring_total / HIST_DEPTH);
            sum_sq      = '0;
            valid_cnt   = 0;
            slot_cnt    = 0;
        end
    endtask

    // Offer one sample transaction and predict its effect once accepted
    task automatic offer_sample(input logic signed [SMP_W-1:0] s, input logic ok,
                                input logic typed, input meter_result_t want);
        bit            closed;
        meter_result_t res;
        regs_idle = 1'b0;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= s;
        sample_ok <= ok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rms_window_step(s, ok, closed, res);
        if (closed)
            pending_windows.push_back(typed ? want : res);
    endtask

    // Registers change only once every outstanding window has been reported
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (!regs_idle)
        begin
            in_valid <= 1'b0;
            while (pending_windows.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            regs_idle = 1'b1;
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_BIAS: bias_q = data[SMP_W-1:0];
            CFG_GAIN: gain_q = data[GAIN_W-1:0];
            CFG_SPW:  spw_q  = data[WIN_W-1:0];
            default:  ;
        endcase
    endtask

    // Mostly near the bias, as a real current waveform would sit; the rest anywhere
    function automatic logic signed [SMP_W-1:0] pick_sample();
        int delta;
        delta = int'($urandom_range(4095)) - 2048;
        if ($urandom_range(99) < 70)
            return bias_q + SMP_W'(delta);
        return SMP_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bias();
        int r;
        logic [SMP_W-1:0] v;
        r = $urandom_range(99);
        if (r < 10)
            v = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        else if (r < 50)
            v = SMP_W'($urandom);
        else
            v = SMP_W'(int'($urandom_range(4095)) - 2048);
        return {8'($urandom), v};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 60)
            return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(1 << 18));
    endfunction

    initial
    begin
        int i;
        int k;
        int r;
        int phase;
        int ok_pct;
        int n_items;
        int rand_items;
        logic [WIN_W-1:0] spw;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                offer_sample(dir_rows[i].smp, dir_rows[i].ok, dir_rows[i].typed,
                             dir_rows[i].want);
        end

        phase      = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 51; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 51; end
                default: begin idle_pct = 6; stall_pct <= 6; end
            endcase
            r = $urandom_range(99);
            if (phase == 2)
                spw = 13'd1;
            else if (r < 5)
                spw = '0;
            else if (r < 12)
                spw = 13'd1;
            else if (r < 85)
                spw = WIN_W'($urandom_range(12, 2));
            else
                spw = WIN_W'($urandom_range(64, 13));
            case ($urandom_range(3))
                0: ok_pct = 100;
                1: ok_pct = 90;
                2: ok_pct = 75;
                default: ok_pct = 50;
            endcase
            write_reg(CFG_BIAS, pick_bias());
            write_reg(CFG_GAIN, pick_gain());
            write_reg(CFG_SPW, {11'($urandom), spw});
            // one-slot windows against a long receiver hold-off back up into the input
            if (phase == 2)
                hold_go <= 1'b1;
            n_items = $urandom_range(100, 60);
            repeat (n_items)
                offer_sample(pick_sample(), $urandom_range(99) < ok_pct, 1'b0, '0);
            rand_items = rand_items + n_items;
            phase      = phase + 1;
        end

        // A long window, then an over-range length that clamps and leaves its window open
        idle_pct = 0;
        stall_pct <= 0;
        for (k = 0; k < 2; k++)
        begin
            write_reg(CFG_BIAS, {8'd0, 16'(int'($urandom_range(4095)) - 2048)});
            write_reg(CFG_GAIN, pick_gain());
            write_reg(CFG_SPW, (k == 0) ? CFG_DATA_W'(LONG_WIN) : CFG_DATA_W'(WIN_MAX));
            repeat ((k == 0) ? LONG_WIN : TAIL_ITEMS)
                offer_sample(pick_sample(), $urandom_range(99) < ((k == 0) ? 85 : 70),
                             1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_windows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
